// ===== hw/rtl/awu_pkg.sv =====
package awu_pkg;

   localparam int WordWidth  = 32;
   localparam int FracBits   = 24;
   localparam int ScaleBits  = 16;
   localparam int RegWidth   = 32;
   localparam int RegIdxBits = 3;
   localparam int RootWidth  = 44;
   localparam int RemWidth   = RootWidth + 2;
   localparam int DivBits    = 64;
   localparam int NumBits    = 96;
   localparam int DenWidth   = RootWidth + 1;

   localparam logic signed [WordWidth-1:0] WordMax = {1'b0, {(WordWidth-1){1'b1}}};
   localparam logic signed [WordWidth-1:0] WordMin = {1'b1, {(WordWidth-1){1'b0}}};
   localparam logic [FracBits:0] OneQ = {1'b1, {FracBits{1'b0}}};

   typedef enum logic [RegIdxBits-1:0] {
      REG_LEARNING_RATE     = 3'd0,
      REG_FIRST_DECAY       = 3'd1,
      REG_SECOND_DECAY      = 3'd2,
      REG_DENOM_EPSILON     = 3'd3,
      REG_WEIGHT_DECAY      = 3'd4,
      REG_FIRST_BIAS_SCALE  = 3'd5,
      REG_SECOND_BIAS_SCALE = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] weight;
      logic signed [WordWidth-1:0] gradient;
      logic signed [WordWidth-1:0] first_moment;
      logic        [WordWidth-2:0] second_moment;
   } req_type;

   typedef struct packed {
      logic signed [WordWidth-1:0] new_weight;
      logic signed [WordWidth-1:0] new_first_moment;
      logic        [WordWidth-2:0] new_second_moment;
      logic                        saturated;
   } rsp_type;

   typedef struct packed {
      logic [24:0] learning_rate;
      logic [23:0] first_decay;
      logic [23:0] second_decay;
      logic [24:0] denom_epsilon;
      logic [24:0] weight_decay;
      logic [31:0] first_bias_scale;
      logic [31:0] second_bias_scale;
   } csr_type;

   // signed a*b >> s, rounded half away from zero, clipped to word; sat in [0]
   function automatic logic [WordWidth:0] mul_rs(input logic signed [WordWidth:0] a,
                                                  input logic signed [WordWidth:0] b,
                                                  input int unsigned s);
      logic              neg;
      logic [WordWidth:0] ma;
      logic [WordWidth:0] mb;
      logic [2*WordWidth+1:0] p;
      logic [2*WordWidth+1:0] q;
      logic [WordWidth-1:0] r;
      logic sat;
      neg = a[WordWidth] ^ b[WordWidth];
      ma = a[WordWidth] ? WordWidth'(1) + ~a : a;
      mb = b[WordWidth] ? WordWidth'(1) + ~b : b;
      p = ma * mb;
      p = p + ((2*WordWidth+2)'(1) << (s - 1));
      q = p >> s;
      if (q == '0) neg = 1'b0;
      sat = 1'b0;
      if (neg) begin
         if (q > {1'b1, {(WordWidth-1){1'b0}}}) begin
            sat = 1'b1;
            r = WordMin;
         end else begin
            r = WordWidth'(~q + 1'b1);
         end
      end else begin
         if (q > WordMax) begin
            sat = 1'b1;
            r = WordMax;
         end else begin
            r = q[WordWidth-1:0];
         end
      end
      return {r, sat};
   endfunction

   function automatic logic [WordWidth:0] clip_s(input logic signed [WordWidth+1:0] x);
      if (x > $signed({2'b00, WordMax})) return {WordMax, 1'b1};
      if (x < $signed({2'b11, WordMin})) return {WordMin, 1'b1};
      return {x[WordWidth-1:0], 1'b0};
   endfunction

endpackage

// ===== hw/rtl/adam_weight_update_unit.sv =====
// Adam weight update with L2 decay on signed Q8.24 words. One transaction is
// accepted per clock while the output is not stalled, and the result passes
// through 150 register stages: six arithmetic stages, a 44-step square root and
// a 96-step divider each with its own input register, the numerator multiply
// and the output register. A stall on rsp_ready freezes the whole pipeline and
// drops req_ready until the held result is taken.
module adam_weight_update_unit import awu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_write,
   input  logic [RegIdxBits-1:0] csr_index,
   input  logic [RegWidth-1:0]   csr_data
);

   csr_type csr_ff;
   logic    adv;
   logic    out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.learning_rate     <= 25'd16777;
         csr_ff.first_decay       <= 24'd15099494;
         csr_ff.second_decay      <= 24'd16760439;
         csr_ff.denom_epsilon     <= 25'd1;
         csr_ff.weight_decay      <= 25'd0;
         csr_ff.first_bias_scale  <= 32'd65536;
         csr_ff.second_bias_scale <= 32'd65536;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_LEARNING_RATE:     csr_ff.learning_rate     <= csr_data[24:0];
            REG_FIRST_DECAY:       csr_ff.first_decay       <= csr_data[23:0];
            REG_SECOND_DECAY:      csr_ff.second_decay      <= csr_data[23:0];
            REG_DENOM_EPSILON:     csr_ff.denom_epsilon     <= csr_data[24:0];
            REG_WEIGHT_DECAY:      csr_ff.weight_decay      <= csr_data[24:0];
            REG_FIRST_BIAS_SCALE:  csr_ff.first_bias_scale  <= csr_data;
            REG_SECOND_BIAS_SCALE: csr_ff.second_bias_scale <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: decay product
   logic                 s1v_ff;
   req_type              s1d_ff;
   logic [WordWidth:0]   s1p_ff;

   always_ff @(posedge clock) begin
      if (reset) s1v_ff <= 1'b0;
      else if (adv) s1v_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s1d_ff <= req_data;
         s1p_ff <= mul_rs($signed({1'b0, WordWidth'(csr_ff.weight_decay)}),
                          $signed({req_data.weight[WordWidth-1], req_data.weight}),
                          FracBits);
      end
   end

   // stage 2: gradient
   logic                        s2v_ff;
   logic signed [WordWidth-1:0] s2w_ff, s2m_ff, s2g_ff;
   logic        [WordWidth-2:0] s2v2_ff;
   logic                        s2s_ff;
   logic [WordWidth:0]          g_in;

   assign g_in = clip_s($signed({{2{s1d_ff.gradient[WordWidth-1]}}, s1d_ff.gradient})
                      + $signed({{2{s1p_ff[WordWidth]}}, s1p_ff[WordWidth:1]}));

   always_ff @(posedge clock) begin
      if (reset) s2v_ff <= 1'b0;
      else if (adv) s2v_ff <= s1v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s2w_ff  <= s1d_ff.weight;
         s2m_ff  <= s1d_ff.first_moment;
         s2v2_ff <= s1d_ff.second_moment;
         s2g_ff  <= g_in[WordWidth:1];
         s2s_ff  <= s1p_ff[0] | g_in[0];
      end
   end

   // stage 3: moment products and g squared
   logic                        s3v_ff;
   logic signed [WordWidth-1:0] s3w_ff;
   logic        [WordWidth-2:0] s3v2_ff;
   logic [WordWidth:0]          s3a_ff, s3b_ff, s3g2_ff;
   logic                        s3s_ff;

   always_ff @(posedge clock) begin
      if (reset) s3v_ff <= 1'b0;
      else if (adv) s3v_ff <= s2v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s3w_ff  <= s2w_ff;
         s3v2_ff <= s2v2_ff;
         s3s_ff  <= s2s_ff;
         s3a_ff  <= mul_rs($signed({1'b0, WordWidth'(csr_ff.first_decay)}),
                           $signed({s2m_ff[WordWidth-1], s2m_ff}), FracBits);
         s3b_ff  <= mul_rs($signed({1'b0, WordWidth'(OneQ - csr_ff.first_decay)}),
                           $signed({s2g_ff[WordWidth-1], s2g_ff}), FracBits);
         s3g2_ff <= mul_rs($signed({s2g_ff[WordWidth-1], s2g_ff}),
                           $signed({s2g_ff[WordWidth-1], s2g_ff}), FracBits);
      end
   end

   // stage 4: first moment sum, second moment products
   logic                        s4v_ff;
   logic signed [WordWidth-1:0] s4w_ff, s4mn_ff;
   logic [WordWidth:0]          s4c_ff, s4d_ff;
   logic                        s4s_ff;
   logic [WordWidth:0]          mn_in;

   assign mn_in = clip_s($signed({{2{s3a_ff[WordWidth]}}, s3a_ff[WordWidth:1]})
                       + $signed({{2{s3b_ff[WordWidth]}}, s3b_ff[WordWidth:1]}));

   always_ff @(posedge clock) begin
      if (reset) s4v_ff <= 1'b0;
      else if (adv) s4v_ff <= s3v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s4w_ff  <= s3w_ff;
         s4mn_ff <= mn_in[WordWidth:1];
         s4s_ff  <= s3s_ff | s3a_ff[0] | s3b_ff[0] | s3g2_ff[0] | mn_in[0];
         s4c_ff  <= mul_rs($signed({1'b0, WordWidth'(csr_ff.second_decay)}),
                           $signed({2'b00, s3v2_ff}), FracBits);
         s4d_ff  <= mul_rs($signed({1'b0, WordWidth'(OneQ - csr_ff.second_decay)}),
                           $signed({s3g2_ff[WordWidth], s3g2_ff[WordWidth:1]}), FracBits);
      end
   end

   // stage 5: second moment sum, first bias correction
   logic                        s5v_ff;
   logic signed [WordWidth-1:0] s5w_ff, s5mn_ff, s5vn_ff;
   logic [WordWidth:0]          s5mh_ff;
   logic                        s5s_ff;
   logic signed [WordWidth+1:0] vsum;
   logic signed [WordWidth-1:0] vn_val;
   logic                        vn_sat;

   assign vsum = $signed({{2{s4c_ff[WordWidth]}}, s4c_ff[WordWidth:1]})
               + $signed({{2{s4d_ff[WordWidth]}}, s4d_ff[WordWidth:1]});
   always_comb begin
      vn_sat = 1'b0;
      vn_val = vsum[WordWidth-1:0];
      if (vsum > $signed({2'b00, WordMax})) begin
         vn_val = WordMax;
         vn_sat = 1'b1;
      end else if (vsum < 0) begin
         vn_val = '0;
         vn_sat = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s5v_ff <= 1'b0;
      else if (adv) s5v_ff <= s4v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s5w_ff  <= s4w_ff;
         s5mn_ff <= s4mn_ff;
         s5vn_ff <= vn_val;
         s5s_ff  <= s4s_ff | s4c_ff[0] | s4d_ff[0] | vn_sat;
         s5mh_ff <= mul_rs($signed({s4mn_ff[WordWidth-1], s4mn_ff}),
                           $signed({1'b0, csr_ff.first_bias_scale}), ScaleBits);
      end
   end

   // stage 6: second bias correction, step magnitude
   logic                        s6v_ff;
   logic signed [WordWidth-1:0] s6w_ff, s6mn_ff, s6vn_ff;
   logic [WordWidth:0]          s6vh_ff;
   logic [WordWidth-1:0]        s6mag_ff;
   logic                        s6neg_ff;
   logic                        s6s_ff;

   always_ff @(posedge clock) begin
      if (reset) s6v_ff <= 1'b0;
      else if (adv) s6v_ff <= s5v_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         s6w_ff   <= s5w_ff;
         s6mn_ff  <= s5mn_ff;
         s6vn_ff  <= s5vn_ff;
         s6s_ff   <= s5s_ff | s5mh_ff[0];
         s6neg_ff <= s5mh_ff[WordWidth];
         s6mag_ff <= s5mh_ff[WordWidth] ? WordWidth'(~s5mh_ff[WordWidth:1] + 1'b1)
                                        : s5mh_ff[WordWidth:1];
         s6vh_ff  <= mul_rs($signed({s5vn_ff[WordWidth-1], s5vn_ff}),
                            $signed({1'b0, csr_ff.second_bias_scale}), ScaleBits);
      end
   end

   logic                 rd_valid, rd_over, rd_zero, rd_neg, rd_nz;
   logic [DivBits-1:0]   rd_quot;
   logic [WordWidth-1:0] vh_pos;

   assign vh_pos = s6vh_ff[WordWidth] ? '0 : s6vh_ff[WordWidth:1];

   // side data travels along the root and divide chain
   localparam int SideDepth = RootWidth + 2 + NumBits + 1;
   logic [SideDepth-1:0][WordWidth-1:0] sw_ff, smn_ff, svn_ff;
   logic [SideDepth-1:0]                ss_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sw_ff  <= {sw_ff[SideDepth-2:0], s6w_ff};
         smn_ff <= {smn_ff[SideDepth-2:0], s6mn_ff};
         svn_ff <= {svn_ff[SideDepth-2:0], s6vn_ff};
         ss_ff  <= {ss_ff[SideDepth-2:0], s6s_ff | s6vh_ff[0]};
      end
   end

   awu_root_div u_root_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s6v_ff),
      .vh        (vh_pos),
      .lr        (csr_ff.learning_rate),
      .eps       (csr_ff.denom_epsilon),
      .mag       (s6mag_ff),
      .neg       (s6neg_ff),
      .out_valid (rd_valid),
      .quot      (rd_quot),
      .over      (rd_over),
      .zero_den  (rd_zero),
      .out_neg   (rd_neg),
      .mag_nz    (rd_nz)
   );

   // final stage: step, new weight
   logic signed [WordWidth-1:0] step_val;
   logic                        step_sat;
   logic [WordWidth:0]          nw_in;
   logic signed [WordWidth-1:0] w_last;
   rsp_type                     rsp_ff;

   assign w_last = sw_ff[SideDepth-1];

   always_comb begin
      step_sat = 1'b0;
      if (rd_zero) begin
         if (!rd_nz) begin
            step_val = '0;
         end else begin
            step_sat = 1'b1;
            step_val = rd_neg ? WordMin : WordMax;
         end
      end else if (rd_neg && rd_quot != '0) begin
         if (rd_over || rd_quot > DivBits'({1'b1, {(WordWidth-1){1'b0}}})) begin
            step_sat = 1'b1;
            step_val = WordMin;
         end else begin
            step_val = WordWidth'(~rd_quot + 1'b1);
         end
      end else begin
         if (rd_over || rd_quot > DivBits'(WordMax)) begin
            step_sat = 1'b1;
            step_val = WordMax;
         end else begin
            step_val = rd_quot[WordWidth-1:0];
         end
      end
   end

   assign nw_in = clip_s($signed({{2{w_last[WordWidth-1]}}, w_last})
                       - $signed({{2{step_val[WordWidth-1]}}, step_val}));

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= rd_valid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.new_weight        <= nw_in[WordWidth:1];
         rsp_ff.new_first_moment  <= smn_ff[SideDepth-1];
         rsp_ff.new_second_moment <= svn_ff[SideDepth-1][WordWidth-2:0];
         rsp_ff.saturated         <= ss_ff[SideDepth-1] | step_sat | nw_in[0];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/awu_root_div.sv =====
module awu_root_div import awu_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [WordWidth-1:0]         vh,
   input  logic [24:0]                  lr,
   input  logic [24:0]                  eps,
   input  logic [WordWidth-1:0]         mag,
   input  logic                         neg,
   output logic                         out_valid,
   output logic [DivBits-1:0]           quot,
   output logic                         over,
   output logic                         zero_den,
   output logic                         out_neg,
   output logic                         mag_nz
);

   localparam int RootSteps = RootWidth;
   localparam int RadBits   = 2 * RootWidth;

   logic [RootSteps:0]                 rv_ff;
   logic [RootSteps:0][RadBits-1:0]    rn_ff;
   logic [RootSteps:0][RemWidth-1:0]   rr_ff;
   logic [RootSteps:0][RootWidth-1:0]  rq_ff;
   logic [RootSteps:0][24:0]           rlr_ff;
   logic [RootSteps:0][24:0]           reps_ff;
   logic [RootSteps:0][WordWidth-1:0]  rmag_ff;
   logic [RootSteps:0]                 rneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= '0;
      end else if (adv) begin
         rv_ff <= {rv_ff[RootSteps-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rn_ff[0]   <= RadBits'({vh, {FracBits{1'b0}}});
         rr_ff[0]   <= '0;
         rq_ff[0]   <= '0;
         rlr_ff[0]  <= lr;
         reps_ff[0] <= eps;
         rmag_ff[0] <= mag;
         rneg_ff[0] <= neg;
      end
   end

   for (genvar i = 0; i < RootSteps; i++) begin : g_root
      logic [RemWidth-1:0] rem_in;
      logic [RemWidth-1:0] trial_in;
      assign rem_in   = {rr_ff[i][RemWidth-3:0], rn_ff[i][RadBits-1 -: 2]};
      assign trial_in = {rq_ff[i], 2'b01};
      always_ff @(posedge clock) begin
         if (adv) begin
            rn_ff[i+1]   <= {rn_ff[i][RadBits-3:0], 2'b00};
            if (rem_in >= trial_in) begin
               rr_ff[i+1] <= rem_in - trial_in;
               rq_ff[i+1] <= {rq_ff[i][RootWidth-2:0], 1'b1};
            end else begin
               rr_ff[i+1] <= rem_in;
               rq_ff[i+1] <= {rq_ff[i][RootWidth-2:0], 1'b0};
            end
            rlr_ff[i+1]  <= rlr_ff[i];
            reps_ff[i+1] <= reps_ff[i];
            rmag_ff[i+1] <= rmag_ff[i];
            rneg_ff[i+1] <= rneg_ff[i];
         end
      end
   end

   // numerator multiply stage
   logic                       nv_ff;
   logic [DenWidth-1:0]        den_ff;
   logic [NumBits-1:0]         num_ff;
   logic                       nneg_ff;
   logic                       nnz_ff;
   logic [DenWidth-1:0]        den_in;

   assign den_in = DenWidth'(rq_ff[RootSteps]) + DenWidth'(reps_ff[RootSteps]);

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff <= 1'b0;
      end else if (adv) begin
         nv_ff <= rv_ff[RootSteps];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff  <= den_in;
         num_ff  <= NumBits'(rlr_ff[RootSteps] * rmag_ff[RootSteps])
                    + NumBits'(den_in >> 1);
         nneg_ff <= rneg_ff[RootSteps];
         nnz_ff  <= rmag_ff[RootSteps] != '0;
      end
   end

   // restoring division, one quotient bit per stage, upper bits fold into overflow
   localparam int DivSteps = NumBits;

   logic [DivSteps:0]                  dv_ff;
   logic [DivSteps:0][NumBits-1:0]     dn_ff;
   logic [DivSteps:0][DenWidth:0]      dr_ff;
   logic [DivSteps:0][DivBits-1:0]     dq_ff;
   logic [DivSteps:0][DenWidth-1:0]    dd_ff;
   logic [DivSteps:0]                  dov_ff;
   logic [DivSteps:0]                  dneg_ff;
   logic [DivSteps:0]                  dnz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (adv) begin
         dv_ff <= {dv_ff[DivSteps-1:0], nv_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dn_ff[0]   <= num_ff;
         dr_ff[0]   <= '0;
         dq_ff[0]   <= '0;
         dd_ff[0]   <= den_ff;
         dov_ff[0]  <= 1'b0;
         dneg_ff[0] <= nneg_ff;
         dnz_ff[0]  <= nnz_ff;
      end
   end

   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      localparam int BitPos = DivSteps - 1 - j;
      logic [DenWidth+1:0] rem_in;
      assign rem_in = {dr_ff[j], dn_ff[j][NumBits-1]};
      always_ff @(posedge clock) begin
         if (adv) begin
            dn_ff[j+1]   <= {dn_ff[j][NumBits-2:0], 1'b0};
            dd_ff[j+1]   <= dd_ff[j];
            dneg_ff[j+1] <= dneg_ff[j];
            dnz_ff[j+1]  <= dnz_ff[j];
            if (dd_ff[j] != '0 && rem_in >= (DenWidth+2)'(dd_ff[j])) begin
               dr_ff[j+1] <= (DenWidth+1)'(rem_in - (DenWidth+2)'(dd_ff[j]));
               if (BitPos >= DivBits) begin
                  dov_ff[j+1] <= 1'b1;
                  dq_ff[j+1]  <= dq_ff[j];
               end else begin
                  dov_ff[j+1] <= dov_ff[j];
                  dq_ff[j+1]  <= dq_ff[j] | (DivBits'(1) << (BitPos % DivBits));
               end
            end else begin
               dr_ff[j+1]  <= (DenWidth+1)'(rem_in);
               dq_ff[j+1]  <= dq_ff[j];
               dov_ff[j+1] <= dov_ff[j];
            end
         end
      end
   end

   assign out_valid = dv_ff[DivSteps];
   assign quot      = dq_ff[DivSteps];
   assign over      = dov_ff[DivSteps];
   assign zero_den  = dd_ff[DivSteps] == '0;
   assign out_neg   = dneg_ff[DivSteps];
   assign mag_nz    = dnz_ff[DivSteps];

endmodule

// ===== hw/rtl/awu_checker.sv =====
module awu_checker import awu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp dropped");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("rsp changed");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("accepted while stalled");

   a_idle_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("valid after reset");

endmodule

bind adam_weight_update_unit awu_checker u_awu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
